// File: design/mcpwm_pkg.sv
`default_nettype none

package mcpwm_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TW       = 27;
    localparam int PIN_W    = 6;
    localparam int FREQ_W   = 10;
    localparam int DUTY_W   = 7;
    localparam int ST_W     = 2;
    localparam int REQ_W    = 2;
    localparam int CNT_W    = $clog2(TW + 1);

    // Division of the period by 100 through reciprocal multiplication.
    localparam int QUO_W     = 21;
    localparam int RCP_W     = 28;
    localparam int RCP_SHIFT = 34;
    localparam int PART_W    = 7;
    localparam int FRAC_W    = PART_W + DUTY_W;
    localparam int FRAC_SHIFT = 20;

    localparam logic [TW-1:0]     TPS_RESET  = TW'(1000000);
    localparam logic [FREQ_W-1:0] FREQ_LIMIT = FREQ_W'(500);
    localparam logic [DUTY_W-1:0] PERCENT    = DUTY_W'(100);
    localparam logic [RCP_W-1:0]  RCP_PCT    = RCP_W'(171798692);
    localparam logic [FRAC_W-1:0] RCP_FRAC   = FRAC_W'(10486);

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK = 2'd0,
        REQ_CFG  = 2'd1,
        REQ_STOP = 2'd2,
        REQ_NOP  = 2'd3
    } req_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_FREQ = 2'd1,
        ST_DUTY = 2'd2,
        ST_NOCH = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;
        logic quick;
        logic start;
        logic div_step;
        logic mul_load;
        logic split_load;
        logic sum_load;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_valid;
        logic out_free;
        logic long_op;
        logic div_last;
    } sts_t;

endpackage

`default_nettype wire

// File: design/mcpwm_if.sv
`default_nettype none

interface mcpwm_req_if;
    logic                           valid;
    logic                           ready;
    logic [mcpwm_pkg::REQ_W-1:0]    req_type;
    logic [mcpwm_pkg::PIN_W-1:0]    pin_number;
    logic [mcpwm_pkg::FREQ_W-1:0]   frequency_hz;
    logic [mcpwm_pkg::DUTY_W-1:0]   duty_percent;

    modport source (output valid, req_type, pin_number, frequency_hz, duty_percent,
                    input ready);
    modport sink   (input valid, req_type, pin_number, frequency_hz, duty_percent,
                    output ready);
endinterface

interface mcpwm_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [mcpwm_pkg::ST_W-1:0]       status;
    logic [mcpwm_pkg::CH_W-1:0]       channel_index;
    logic [mcpwm_pkg::CHANNELS-1:0]   output_levels;
    logic [mcpwm_pkg::CHANNELS-1:0]   active_mask;

    modport source (output valid, status, channel_index, output_levels, active_mask,
                    input ready);
    modport sink   (input valid, status, channel_index, output_levels, active_mask,
                    output ready);
endinterface

`default_nettype wire

// File: design/mcpwm_ctrl.sv
`default_nettype none

module mcpwm_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mcpwm_pkg::sts_t sts,
    output mcpwm_pkg::cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DIV_PER = 6'b000010,
        S_MUL     = 6'b000100,
        S_SPLIT   = 6'b001000,
        S_SUM     = 6'b010000,
        S_COMMIT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    always_comb
    begin
        cmd.ready      = (state_reg == S_IDLE) && sts.out_free;
        take           = cmd.ready && sts.req_valid;
        cmd.start      = take && sts.long_op;
        cmd.quick      = take && !sts.long_op;
        cmd.div_step   = (state_reg == S_DIV_PER);
        cmd.mul_load   = (state_reg == S_MUL);
        cmd.split_load = (state_reg == S_SPLIT);
        cmd.sum_load   = (state_reg == S_SUM);
        cmd.commit     = (state_reg == S_COMMIT);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = S_DIV_PER;
                end
            end
            S_DIV_PER:
            begin
                if (sts.div_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A divide phase must end on its last step before the next phase starts.
    a_per_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_PER && sts.div_last) |=> (state_reg == S_MUL))
        else $error("period divide did not hand over to the multiply");

    a_commit_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |-> ($past(state_reg) == S_SUM))
        else $error("commit reached without finishing the duty scaling");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd.ready)
        else $error("request taken while a configure is in flight");

endmodule

`default_nettype wire

// File: design/mcpwm_dp.sv
`default_nettype none

module mcpwm_dp
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [mcpwm_pkg::TW-1:0]     cfg_wdata,
    input  wire mcpwm_pkg::cmd_t              cmd,
    output mcpwm_pkg::sts_t                   sts,
    mcpwm_req_if.sink                         req,
    mcpwm_rsp_if.source                       rsp
);

    logic [mcpwm_pkg::TW-1:0] tps_reg;

    // Channel state.
    logic [mcpwm_pkg::PIN_W-1:0] pin_reg    [mcpwm_pkg::CHANNELS];
    logic [mcpwm_pkg::PIN_W-1:0] pin_next   [mcpwm_pkg::CHANNELS];
    logic [mcpwm_pkg::CHANNELS-1:0] bound_reg, bound_next;
    logic [mcpwm_pkg::CHANNELS-1:0] run_reg, run_next;
    logic [mcpwm_pkg::TW-1:0] period_reg [mcpwm_pkg::CHANNELS];
    logic [mcpwm_pkg::TW-1:0] period_next[mcpwm_pkg::CHANNELS];
    logic [mcpwm_pkg::TW-1:0] high_reg   [mcpwm_pkg::CHANNELS];
    logic [mcpwm_pkg::TW-1:0] high_next  [mcpwm_pkg::CHANNELS];
    logic [mcpwm_pkg::TW-1:0] phase_reg  [mcpwm_pkg::CHANNELS];
    logic [mcpwm_pkg::TW-1:0] phase_next [mcpwm_pkg::CHANNELS];

    // Latched configure request.
    logic [mcpwm_pkg::PIN_W-1:0]  req_pin_reg;
    logic [mcpwm_pkg::FREQ_W-1:0] freq_reg;
    logic [mcpwm_pkg::DUTY_W-1:0] duty_reg;
    logic [mcpwm_pkg::CH_W-1:0]   ch_reg;

    // Bit-serial restoring divider for the period.
    logic [mcpwm_pkg::TW-1:0]     q_reg;
    logic [mcpwm_pkg::FREQ_W-1:0] rem_reg;
    logic [mcpwm_pkg::FREQ_W-1:0] dvs_reg;
    logic [mcpwm_pkg::CNT_W-1:0]  cnt_reg;
    logic [mcpwm_pkg::FREQ_W:0]   trial;
    logic [mcpwm_pkg::FREQ_W:0]   diff;
    logic                         qbit;
    logic [mcpwm_pkg::TW-1:0]     per_val;

    // Duty scaling: period = 100 * quo + part, high = quo * duty + part * duty / 100.
    logic [mcpwm_pkg::TW+mcpwm_pkg::RCP_W-1:0] rcp_prod;
    logic [mcpwm_pkg::QUO_W-1:0]               quo_reg;
    logic [mcpwm_pkg::TW-1:0]                  quo_x100;
    logic [mcpwm_pkg::PART_W-1:0]              part;
    logic [mcpwm_pkg::TW-1:0]                  whole_reg;
    logic [mcpwm_pkg::FRAC_W-1:0]              frac_reg;
    logic [2*mcpwm_pkg::FRAC_W-1:0]            frac_prod;
    logic [mcpwm_pkg::TW-1:0]                  high_val;

    // Output register.
    logic                           out_valid_reg;
    logic [mcpwm_pkg::ST_W-1:0]     out_status_reg;
    logic [mcpwm_pkg::CH_W-1:0]     out_ch_reg;
    logic [mcpwm_pkg::CHANNELS-1:0] out_lv_reg;
    logic [mcpwm_pkg::CHANNELS-1:0] out_am_reg;

    logic                           cfg_found, free_found, stop_found, have_ch;
    logic [mcpwm_pkg::CH_W-1:0]     cfg_ch, free_ch, stop_ch, sel_ch;
    logic                           freq_bad, duty_bad, is_tick, is_stop;
    logic [mcpwm_pkg::ST_W-1:0]     q_status;
    logic [mcpwm_pkg::CH_W-1:0]     q_ch;
    logic [mcpwm_pkg::CHANNELS-1:0] lv;
    logic [mcpwm_pkg::TW:0]         nx [mcpwm_pkg::CHANNELS];
    logic                           out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= mcpwm_pkg::TPS_RESET;
        end
        else if (cfg_we)
        begin
            tps_reg <= cfg_wdata;
        end
    end

    // Channel lookup against the incoming request.
    always_comb
    begin
        cfg_found  = 1'b0;
        free_found = 1'b0;
        stop_found = 1'b0;
        cfg_ch     = '0;
        free_ch    = '0;
        stop_ch    = '0;
        for (int i = 0; i < mcpwm_pkg::CHANNELS; i++)
        begin
            if (!cfg_found && bound_reg[i] && pin_reg[i] == req.pin_number)
            begin
                cfg_found = 1'b1;
                cfg_ch    = mcpwm_pkg::CH_W'(i);
            end
            if (!free_found && !run_reg[i])
            begin
                free_found = 1'b1;
                free_ch    = mcpwm_pkg::CH_W'(i);
            end
            if (!stop_found && bound_reg[i] && run_reg[i] && pin_reg[i] == req.pin_number)
            begin
                stop_found = 1'b1;
                stop_ch    = mcpwm_pkg::CH_W'(i);
            end
        end
    end

    assign sel_ch   = cfg_found ? cfg_ch : free_ch;
    assign have_ch  = cfg_found || free_found;
    assign freq_bad = req.frequency_hz > mcpwm_pkg::FREQ_LIMIT;
    assign duty_bad = req.duty_percent > mcpwm_pkg::PERCENT;
    assign is_tick  = mcpwm_pkg::req_t'(req.req_type) == mcpwm_pkg::REQ_TICK;
    assign is_stop  = mcpwm_pkg::req_t'(req.req_type) == mcpwm_pkg::REQ_STOP;

    always_comb
    begin
        q_status = mcpwm_pkg::ST_OK;
        q_ch     = '0;
        unique case (mcpwm_pkg::req_t'(req.req_type))
            mcpwm_pkg::REQ_TICK:
            begin
                q_status = mcpwm_pkg::ST_OK;
            end
            mcpwm_pkg::REQ_CFG:
            begin
                // Frequency is checked before duty.
                if (freq_bad)
                begin
                    q_status = mcpwm_pkg::ST_FREQ;
                end
                else if (duty_bad)
                begin
                    q_status = mcpwm_pkg::ST_DUTY;
                end
                else
                begin
                    q_status = mcpwm_pkg::ST_NOCH;
                end
            end
            mcpwm_pkg::REQ_STOP:
            begin
                q_ch = stop_found ? stop_ch : '0;
            end
            mcpwm_pkg::REQ_NOP:
            begin
                q_status = mcpwm_pkg::ST_OK;
            end
        endcase
    end

    assign sts.req_valid = req.valid;
    assign sts.out_free  = !out_valid_reg || rsp.ready;
    assign sts.long_op   = (mcpwm_pkg::req_t'(req.req_type) == mcpwm_pkg::REQ_CFG)
                           && !freq_bad && !duty_bad && have_ch;
    assign sts.div_last  = (cnt_reg == mcpwm_pkg::CNT_W'(1));
    assign req.ready     = cmd.ready;

    // Divider datapath.
    assign trial   = {rem_reg, q_reg[mcpwm_pkg::TW-1]};
    assign qbit    = trial >= {1'b0, dvs_reg};
    assign diff    = trial - {1'b0, dvs_reg};
    assign per_val = (freq_reg == '0) ? '0 : q_reg;

    // Scaling datapath, one registered step per state.
    assign rcp_prod  = (mcpwm_pkg::TW + mcpwm_pkg::RCP_W)'(per_val)
                       * (mcpwm_pkg::TW + mcpwm_pkg::RCP_W)'(mcpwm_pkg::RCP_PCT);
    assign quo_x100  = mcpwm_pkg::TW'(quo_reg) * mcpwm_pkg::TW'(mcpwm_pkg::PERCENT);
    assign part      = mcpwm_pkg::PART_W'(per_val - quo_x100);
    assign frac_prod = (2 * mcpwm_pkg::FRAC_W)'(frac_reg)
                       * (2 * mcpwm_pkg::FRAC_W)'(mcpwm_pkg::RCP_FRAC);
    assign high_val  = whole_reg
                       + mcpwm_pkg::TW'(frac_prod[2*mcpwm_pkg::FRAC_W-1:mcpwm_pkg::FRAC_SHIFT]);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_pin_reg <= req.pin_number;
            freq_reg    <= req.frequency_hz;
            duty_reg    <= req.duty_percent;
            ch_reg      <= sel_ch;
            q_reg       <= tps_reg;
            rem_reg     <= '0;
            dvs_reg     <= req.frequency_hz;
            cnt_reg     <= mcpwm_pkg::CNT_W'(mcpwm_pkg::TW);
        end
        else if (cmd.div_step)
        begin
            q_reg   <= {q_reg[mcpwm_pkg::TW-2:0], qbit};
            rem_reg <= qbit ? diff[mcpwm_pkg::FREQ_W-1:0] : trial[mcpwm_pkg::FREQ_W-1:0];
            cnt_reg <= cnt_reg - mcpwm_pkg::CNT_W'(1);
        end
        else if (cmd.mul_load)
        begin
            quo_reg <= rcp_prod[mcpwm_pkg::TW+mcpwm_pkg::RCP_W-1:mcpwm_pkg::RCP_SHIFT];
            for (int i = 0; i < mcpwm_pkg::CHANNELS; i++)
            begin
                if (ch_reg == mcpwm_pkg::CH_W'(i))
                begin
                    period_reg[i] <= per_val;
                end
            end
        end
        else if (cmd.split_load)
        begin
            whole_reg <= mcpwm_pkg::TW'(quo_reg) * mcpwm_pkg::TW'(duty_reg);
            frac_reg  <= mcpwm_pkg::FRAC_W'(part) * mcpwm_pkg::FRAC_W'(duty_reg);
        end
        else if (cmd.sum_load)
        begin
            // The quotient register holds the high time until the commit.
            q_reg <= high_val;
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < mcpwm_pkg::CHANNELS; i++)
            begin
                period_reg[i] <= period_next[i];
            end
        end
    end

    // Next channel state for tick, stop and configure commit.
    always_comb
    begin
        bound_next = bound_reg;
        run_next   = run_reg;
        for (int i = 0; i < mcpwm_pkg::CHANNELS; i++)
        begin
            pin_next[i]    = pin_reg[i];
            period_next[i] = period_reg[i];
            high_next[i]   = high_reg[i];
            phase_next[i]  = phase_reg[i];
            nx[i]          = {1'b0, phase_reg[i]} + 1'b1;
            if (cmd.quick && is_tick && run_reg[i])
            begin
                phase_next[i] = (nx[i] >= {1'b0, period_reg[i]}) ? '0
                                : nx[i][mcpwm_pkg::TW-1:0];
            end
            if (cmd.quick && is_stop && stop_found && stop_ch == mcpwm_pkg::CH_W'(i))
            begin
                run_next[i] = 1'b0;
            end
            if (cmd.commit && ch_reg == mcpwm_pkg::CH_W'(i))
            begin
                pin_next[i]   = req_pin_reg;
                bound_next[i] = 1'b1;
                run_next[i]   = 1'b1;
                high_next[i]  = q_reg;
                phase_next[i] = '0;
            end
            lv[i] = run_next[i] && (phase_next[i] < high_next[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg <= '0;
            run_reg   <= '0;
            for (int i = 0; i < mcpwm_pkg::CHANNELS; i++)
            begin
                pin_reg[i]   <= '0;
                high_reg[i]  <= '0;
                phase_reg[i] <= '0;
            end
        end
        else
        begin
            bound_reg <= bound_next;
            run_reg   <= run_next;
            for (int i = 0; i < mcpwm_pkg::CHANNELS; i++)
            begin
                pin_reg[i]   <= pin_next[i];
                high_reg[i]  <= high_next[i];
                phase_reg[i] <= phase_next[i];
            end
        end
    end

    // Period is only read by running channels, which always were configured first.
    assign out_load = cmd.quick || cmd.commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= cmd.commit ? mcpwm_pkg::ST_OK : q_status;
            out_ch_reg     <= cmd.commit ? ch_reg : q_ch;
            out_lv_reg     <= lv;
            out_am_reg     <= run_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.channel_index = out_ch_reg;
    assign rsp.output_levels = out_lv_reg;
    assign rsp.active_mask   = out_am_reg;

    a_commit_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> run_reg[$past(ch_reg)])
        else $error("configured channel is not running after commit");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && dvs_reg != '0) |-> (rem_reg < dvs_reg))
        else $error("divider remainder escaped its range");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || rsp.ready))
        else $error("result beat overwritten before it was taken");

    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.quick && cmd.commit))
        else $error("two results produced in one cycle");

endmodule

`default_nettype wire

// File: design/multi_channel_pwm_generator.sv
// Tick, stop, no-op and rejected configure beats: result registered in the cycle after
// acceptance, one beat per cycle while the result side keeps up.
// Accepted configure: result and next accepted beat wait on the one bit per cycle
// period divider (27 steps), the multiply, split and sum steps that scale the period by
// the duty, and a commit step that loads the result register.
// Reset: all channels unbound and inactive, ticks_per_second 1000000, no result pending.
`default_nettype none

module multi_channel_pwm_generator
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [mcpwm_pkg::TW-1:0] cfg_wdata,
    mcpwm_req_if.sink                     req,
    mcpwm_rsp_if.source                   rsp
);

    mcpwm_pkg::cmd_t cmd;
    mcpwm_pkg::sts_t sts;

    mcpwm_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    mcpwm_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
